/* sv/lkvc_pkg.sv */
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_entry_store and lru_key_value_cache_top; depends on nothing else.
package lkvc_pkg;

    // Default sizes of the store.
    localparam int CAPACITY_MAX_DEF = 16;
    localparam int KEY_BITS_DEF     = 32;

    // Fixed field widths.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request type codes.
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // One request as held in the input register.
    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_req;

    // One result as produced by the entry store.
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
    } t_result;

endpackage

/* sv/lkvc_entry_store.sv */
// Entry store of the LRU key-value cache: keys, values, valid bits and recency ranks,
// with the parallel key compare and the rank update. Depends on lkvc_pkg.
module lkvc_entry_store #(
    parameter int CAPACITY_MAX = lkvc_pkg::CAPACITY_MAX_DEF,
    parameter int KEY_BITS     = lkvc_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  lkvc_pkg::t_req              i_req,
    input  logic [lkvc_pkg::CAP_W-1:0]  i_capacity,
    output lkvc_pkg::t_result           o_res
);

    localparam int IDX_W = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W = $clog2(CAPACITY_MAX + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    // Key and value slots carry no reset; valid bits, ranks and the count do.
    logic [KEY_BITS-1:0]        r_key   [CAPACITY_MAX];
    logic [lkvc_pkg::DATA_W-1:0] r_value [CAPACITY_MAX];
    logic [CAPACITY_MAX-1:0]    r_valid;
    logic [RANK_W-1:0]          r_rank  [CAPACITY_MAX];
    logic [CNT_W-1:0]           r_count;

    logic [RANK_W-1:0]          n_rank  [CAPACITY_MAX];

    logic [KEY_BITS-1:0]        w_key;
    logic [CAPACITY_MAX-1:0]    w_match;
    logic                       w_hit;
    logic [IDX_W-1:0]           w_found_idx;
    logic [IDX_W-1:0]           w_oldest_idx;
    logic [IDX_W-1:0]           w_free_idx;
    logic                       w_full;
    logic [CMP_W-1:0]           w_cap;
    logic                       w_at_cap;
    logic                       w_put;
    logic                       w_insert;
    logic                       w_replace;
    logic                       w_touch;
    logic                       w_all;
    logic [IDX_W-1:0]           w_slot;
    logic [RANK_W-1:0]          w_limit;

    // The stored key is the low KEY_BITS bits of the field, zero-extended if wider.
    generate
        if (KEY_BITS <= lkvc_pkg::DATA_W) begin : g_key_trunc
            assign w_key = i_req.key[KEY_BITS-1:0];
        end else begin : g_key_ext
            assign w_key = {{(KEY_BITS - lkvc_pkg::DATA_W){1'b0}}, i_req.key};
        end
    endgenerate

    // Parallel compare, oldest-entry and free-slot search over all entries.
    // Valid keys are unique and valid ranks are distinct 0 .. count-1, so the
    // oldest entry is the valid one whose rank is count-1.
    always_comb begin
        w_match      = '0;
        w_found_idx  = '0;
        w_oldest_idx = '0;
        w_free_idx   = '0;
        for (int i = 0; i < CAPACITY_MAX; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == w_key);
            if (w_match[i]) begin
                w_found_idx = IDX_W'(i);
            end
            if (r_valid[i] && (CNT_W'(r_rank[i]) == (r_count - CNT_W'(1)))) begin
                w_oldest_idx = IDX_W'(i);
            end
        end
        for (int i = CAPACITY_MAX - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
        w_hit = |w_match;
    end

    // Effective capacity: zero acts as one, anything above the store size as the size.
    always_comb begin
        w_cap = CMP_W'(i_capacity);
        if (w_cap == '0) begin
            w_cap = CMP_W'(1);
        end else if (w_cap > CMP_W'(CAPACITY_MAX)) begin
            w_cap = CMP_W'(CAPACITY_MAX);
        end
        w_full   = (r_count == CNT_W'(CAPACITY_MAX));
        w_at_cap = (CMP_W'(r_count) >= w_cap) || w_full;
    end

    // Choose the slot to make most recent and the rank limit below which others age.
    always_comb begin
        w_put     = (i_req.req_type == lkvc_pkg::REQ_PUT);
        w_replace = w_put && !w_hit && w_at_cap;
        w_insert  = w_put && !w_hit && !w_at_cap;
        w_touch   = i_en && (w_hit || w_put);
        w_all     = w_insert;
        if (w_hit) begin
            w_slot = w_found_idx;
        end else if (w_replace) begin
            w_slot = w_oldest_idx;
        end else begin
            w_slot = w_free_idx;
        end
        w_limit = r_rank[w_slot];
    end

    // Touched slot goes to rank 0; younger valid entries (all on insert) age by one.
    always_comb begin
        for (int i = 0; i < CAPACITY_MAX; i++) begin
            if (IDX_W'(i) == w_slot) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (w_all || (r_rank[i] < w_limit))) begin
                n_rank[i] = r_rank[i] + RANK_W'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
    end

    // Result: the stored value only on a get hit.
    always_comb begin
        o_res.hit        = w_hit;
        o_res.read_value = (!w_put && w_hit) ? r_value[w_found_idx] : '0;
    end

    // Control state: valid bits, ranks and entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < CAPACITY_MAX; i++) begin
                r_rank[i] <= '0;
            end
        end else if (w_touch) begin
            for (int i = 0; i < CAPACITY_MAX; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (w_insert) begin
                r_valid[w_slot] <= 1'b1;
                r_count         <= r_count + CNT_W'(1);
            end
        end
    end

    // Payload slots: key on insert or replace, value on every put.
    always_ff @(posedge i_clk) begin
        if (i_en && w_put) begin
            r_value[w_slot] <= i_req.value;
            if (!w_hit) begin
                r_key[w_slot] <= w_key;
            end
        end
    end

endmodule

/* sv/lru_key_value_cache_top.sv */
// LRU key-value cache top level: stream handshake, input and result registers.
// A request is held in the input register and its result in the result register, where a stalled receiver holds it.
// Throughput: one request per cycle while the result register is not held back, set by the parallel key compare and
// rank update over all entries between the input register and the result register.
// Reset (synchronous, active low) clears valid bits, ranks and the entry count and
// sets capacity to 16; no clearing pass is needed, so requests are taken at once.
module lru_key_value_cache_top #(
    parameter int CAPACITY_MAX = lkvc_pkg::CAPACITY_MAX_DEF,
    parameter int KEY_BITS     = lkvc_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wr_data,    // capacity
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,     // key [31:0], value [63:32]
    input  logic [0:0]                 s_axis_tuser,     // req_type [0]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,     // read_value [31:0]
    output logic [0:0]                 m_axis_tuser      // hit [0]
);

    logic [lkvc_pkg::CAP_W-1:0] r_capacity;
    logic                       r_in_valid;
    lkvc_pkg::t_req             r_in_req;
    logic                       r_out_valid;
    lkvc_pkg::t_result          r_out_res;

    logic                       n_in_valid;
    logic                       n_out_valid;

    logic                       w_advance;
    lkvc_pkg::t_req             w_req;
    lkvc_pkg::t_result          w_res;

    // The input register moves on when the result register is empty or being taken.
    always_comb begin
        w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
        s_axis_tready = !r_in_valid || w_advance;
        n_in_valid    = (s_axis_tvalid && s_axis_tready) || (r_in_valid && !w_advance);
        n_out_valid   = w_advance || (r_out_valid && !m_axis_tready);
    end

    // Unpack the input transaction.
    always_comb begin
        w_req.req_type = s_axis_tuser[0];
        w_req.key      = s_axis_tdata[31:0];
        w_req.value    = s_axis_tdata[63:32];
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    // Handshake state of the two register stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req <= w_req;
        end
        if (w_advance) begin
            r_out_res <= w_res;
        end
    end

    // Entry store: lookup and update for the request in the input register.
    lkvc_entry_store #(
        .CAPACITY_MAX (CAPACITY_MAX),
        .KEY_BITS     (KEY_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_req      (r_in_req),
        .i_capacity (r_capacity),
        .o_res      (w_res)
    );

    // Result transaction.
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_res.read_value;
    assign m_axis_tuser[0] = r_out_res.hit;

    // A miss always returns a zero value.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("miss result carries a non-zero value");

    // The input side only stalls when a finished result is held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a held result");

    // An accepted request is held in the input register on the next cycle.
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_in_valid)
        else $error("accepted request lost");

    // A request leaving the input register produces a result on the next cycle.
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> m_axis_tvalid)
        else $error("processed request gave no result");

endmodule

/* tb/tb_lru_key_value_cache_top.sv */
// Self-checking testbench for lru_key_value_cache_top: randomised get and put traffic with
// an LRU predictor applied to each accepted request, bursty sender, stalling receiver and capacity changes.
// Depends on lkvc_pkg and lru_key_value_cache_top only.
`timescale 1ns / 100ps

module tb_lru_key_value_cache_top;

    localparam int SLOTS          = lkvc_pkg::CAPACITY_MAX_DEF;
    localparam int POOL_MAX       = 24;
    localparam int ITEMS_PER_SET  = 150;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 10;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_cfg_wr_en   = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0] i_cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [63:0]                s_axis_tdata  = '0;     // key [31:0], value [63:32]
    logic [0:0]                 s_axis_tuser  = '0;     // req_type [0]
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [31:0]                m_axis_tdata;           // read_value [31:0]
    logic [0:0]                 m_axis_tuser;           // hit [0]

    // Predicted contents of the store and the capacity register.
    logic [31:0]                slot_key   [SLOTS];
    logic [31:0]                slot_value [SLOTS];
    bit                         slot_valid [SLOTS];
    int unsigned                slot_rank  [SLOTS];
    logic [lkvc_pkg::CAP_W-1:0] cap_setting = lkvc_pkg::CAP_RESET;

    // Requests waiting to be sent and results still owed by the block.
    lkvc_pkg::t_req    req_queue[$];
    lkvc_pkg::t_result pending_results[$];
    lkvc_pkg::t_req    cur_req;

    // Keys used by the random traffic, so that hits and evictions are frequent.
    logic [31:0] key_pool [POOL_MAX];
    int          pool_size = POOL_MAX;

    int error_count  = 0;
    int stall_cycles = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    int ready_mode   = 0;
    int mode_left    = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;

    lru_key_value_cache_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Make one slot most recent; valid slots ranked below the limit age by one.
    function automatic void promote_slot(input int slot, input int unsigned limit);
        for (int i = 0; i < SLOTS; i++) begin
            if (i != slot && slot_valid[i] && slot_rank[i] < limit) begin
                slot_rank[i]++;
            end
        end
        slot_rank[slot] = 0;
    endfunction

    // Apply one request to the predicted store and return the result it must produce.
    function automatic lkvc_pkg::t_result cache_lookup(input lkvc_pkg::t_req req);
        lkvc_pkg::t_result res;
        int unsigned       eff_cap;
        int unsigned       used;
        int                hit_slot;
        int                free_slot;
        int                lru_slot;
        eff_cap   = 32'(cap_setting);
        used      = 0;
        hit_slot  = -1;
        free_slot = -1;
        lru_slot  = -1;
        if (eff_cap < 1) begin
            eff_cap = 1;
        end
        if (eff_cap > SLOTS) begin
            eff_cap = SLOTS;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) begin
                used++;
                if (slot_key[i] == req.key) begin
                    hit_slot = i;
                end
                if (lru_slot < 0 || slot_rank[i] > slot_rank[lru_slot]) begin
                    lru_slot = i;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        res.hit        = (hit_slot >= 0);
        res.read_value = '0;
        if (req.req_type == lkvc_pkg::REQ_GET) begin
            if (hit_slot >= 0) begin
                res.read_value = slot_value[hit_slot];
                promote_slot(hit_slot, slot_rank[hit_slot]);
            end
        end else if (hit_slot >= 0) begin
            slot_value[hit_slot] = req.value;
            promote_slot(hit_slot, slot_rank[hit_slot]);
        end else if (used >= eff_cap || free_slot < 0) begin
            // Full, or over a lowered capacity: the least recent entry is replaced.
            if (lru_slot >= 0) begin
                slot_key[lru_slot]   = req.key;
                slot_value[lru_slot] = req.value;
                promote_slot(lru_slot, slot_rank[lru_slot]);
            end
        end else begin
            slot_key[free_slot]   = req.key;
            slot_value[free_slot] = req.value;
            slot_valid[free_slot] = 1'b1;
            promote_slot(free_slot, 32'hFFFF_FFFF);
        end
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    task automatic queue_request(input logic kind, input logic [31:0] key,
                                 input logic [31:0] value);
        lkvc_pkg::t_req req;
        req.req_type = kind;
        req.key      = key;
        req.value    = value;
        req_queue.push_back(req);
    endtask

    // Wait until every request has been sent and every result has come back.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (req_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    endtask

    task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cap_setting = cap;
    endtask

    // New key set for a phase: the extremes, a pair one bit apart, the rest random.
    function automatic void refill_key_pool(input int size);
        for (int i = 0; i < POOL_MAX; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = key_pool[5] ^ (32'd1 << $urandom_range(0, 31));
        pool_size   = size;
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 85) begin
            return key_pool[$urandom_range(0, pool_size - 1)];
        end
        return $urandom;
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            queue_request($urandom_range(0, 1) ? lkvc_pkg::REQ_PUT : lkvc_pkg::REQ_GET,
                          pick_key(), $urandom);
        end
    endtask

    // Driver: offers queued requests in bursts of random length with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(cache_lookup(cur_req));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_queue.size() != 0) begin
                    cur_req = req_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_req.value, cur_req.key};
                    s_axis_tuser  <= cur_req.req_type;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transaction and drives the receiver's stall pattern.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result hit=%0b read_value=%08h",
                                       m_axis_tuser[0], m_axis_tdata));
            end else if (m_axis_tuser[0] !== pending_results[0].hit ||
                         m_axis_tdata !== pending_results[0].read_value) begin
                note_failure($sformatf("expected hit=%0b read_value=%08h, got hit=%0b read_value=%08h",
                                       pending_results[0].hit, pending_results[0].read_value,
                                       m_axis_tuser[0], m_axis_tdata));
                void'(pending_results.pop_front());
            end else begin
                void'(pending_results.pop_front());
            end
        end
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ~m_axis_tready;
                2:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: ends the run once no transaction has happened for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus sequence and end of run.
    initial begin
        int phase_caps [12];
        int eff;
        phase_caps = '{31, 16, 17, 4, 2, 8, 1, 0, 12, 16, 5, 3};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small store: misses on empty, extreme keys and values, update and eviction.
        set_capacity(5'd3);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(lkvc_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_request(lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_PUT, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
        queue_request(lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'hDEAD_BEEF);
        queue_request(lkvc_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
        wait_idle();

        // Capacity lowered below the entry count: nothing is dropped, inserts replace.
        set_capacity(5'd1);
        queue_request(lkvc_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_PUT, 32'h0000_0001, 32'hA5A5_A5A5);
        queue_request(lkvc_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_idle();

        // A capacity of zero behaves as one.
        set_capacity(5'd0);
        queue_request(lkvc_pkg::REQ_PUT, 32'h0000_0002, 32'h0000_0002);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0001, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_GET, 32'h0000_0002, 32'h0000_0000);
        queue_request(lkvc_pkg::REQ_PUT, 32'h0000_0002, 32'h8000_0001);
        wait_idle();

        // Random phases, each with its own capacity and key set.
        foreach (phase_caps[p]) begin
            set_capacity(phase_caps[p][lkvc_pkg::CAP_W-1:0]);
            eff = (phase_caps[p] < 1) ? 1 : (phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p];
            refill_key_pool((eff + 6 > POOL_MAX) ? POOL_MAX : eff + 6);
            if (p == 1) begin
                // Receiver holds off for a long stretch while requests keep coming.
                queue_random(40);
                hold_req = 1'b1;
                queue_random(ITEMS_PER_SET - 40);
            end else if (p == 3) begin
                // Sender pauses mid-phase until every result has come back.
                queue_random(60);
                wait_idle();
                queue_random(ITEMS_PER_SET - 60);
            end else begin
                queue_random(ITEMS_PER_SET);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* lru_key_value_cache_top.f */
sv/lkvc_pkg.sv
sv/lkvc_entry_store.sv
sv/lru_key_value_cache_top.sv
tb/tb_lru_key_value_cache_top.sv
